// File: rtl/core/tgpr_pkg.sv
// Shared types and constants for the glyph pixel renderer.
package tgpr_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_SIZE      = 8;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0]         NEWLINE_CODE = 8'd10;
    localparam logic signed [16:0] ADVANCE_X    = 17'sd8;
    localparam logic signed [16:0] LINE_STEP    = 17'sd10;
    localparam logic signed [16:0] COORD_MAX    = 17'sd32767;

    localparam int CFG_AW = 4;

    localparam logic [12:0] WIDTH_RST  = 13'd1920;
    localparam logic [12:0] HEIGHT_RST = 13'd1080;
    localparam logic [15:0] PITCH_RST  = 16'd7680;
    localparam logic [29:0] BASE_RST   = 30'd0;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_DRAW  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_PITCH  = 2'd2,
        REG_BASE   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FETCH,
        BK_SCAN,
        BK_FLUSH
    } back_state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [31:0]        text_color;
        logic [7:0]         char_code;
        logic [2:0]         glyph_row;
        logic [7:0]         row_bits;
    } in_item_t;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic        last_write;
    } out_item_t;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [15:0] row_pitch;
        logic [29:0] buffer_base;
    } cfg_t;

    typedef struct packed {
        logic               is_draw;
        logic [7:0]         char_code;
        logic [2:0]         glyph_row;
        logic [7:0]         row_bits;
        logic signed [15:0] col_pos;
        logic signed [15:0] row_pos;
        logic [31:0]        color;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

endpackage

// File: rtl/core/tgpr_front.sv
// Front end: accepts items, keeps cursor and colour, queues loads and draws.
module tgpr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tgpr_pkg::in_item_t  s_item,
    input  logic                clear_busy,
    input  logic                queue_full,
    output tgpr_pkg::push_t     push
);

    logic signed [15:0] start_col_reg, start_col_next;
    logic signed [15:0] cur_x_reg, cur_x_next;
    logic signed [15:0] cur_y_reg, cur_y_next;
    logic [31:0]        color_reg, color_next;
    logic               accept;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] v,
                                                   input logic signed [16:0] d);
        logic signed [16:0] r;
        r = {v[15], v} + d;
        if (r > tgpr_pkg::COORD_MAX) begin
            return tgpr_pkg::COORD_MAX[15:0];
        end
        return r[15:0];
    endfunction

    always_comb begin
        s_ready        = !clear_busy && !queue_full;
        accept         = s_valid && s_ready;
        start_col_next = start_col_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        color_next     = color_reg;
        push.push          = 1'b0;
        push.job.is_draw   = (s_item.command == tgpr_pkg::CMD_DRAW);
        push.job.char_code = s_item.char_code;
        push.job.glyph_row = s_item.glyph_row;
        push.job.row_bits  = s_item.row_bits;
        push.job.col_pos   = cur_x_reg;
        push.job.row_pos   = cur_y_reg;
        push.job.color     = color_reg;
        if (accept) begin
            case (s_item.command)
                tgpr_pkg::CMD_LOAD: begin
                    push.push = 1'b1;
                end
                tgpr_pkg::CMD_START: begin
                    start_col_next = s_item.origin_x;
                    cur_x_next     = s_item.origin_x;
                    cur_y_next     = s_item.origin_y;
                    color_next     = s_item.text_color;
                end
                tgpr_pkg::CMD_DRAW: begin
                    if (s_item.char_code == tgpr_pkg::NEWLINE_CODE) begin
                        cur_x_next = start_col_reg;
                        cur_y_next = sat_add(cur_y_reg, tgpr_pkg::LINE_STEP);
                    end else begin
                        push.push  = 1'b1;
                        cur_x_next = sat_add(cur_x_reg, tgpr_pkg::ADVANCE_X);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_col_reg <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            color_reg     <= '0;
        end else begin
            start_col_reg <= start_col_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            color_reg     <= color_next;
        end
    end

endmodule

// File: rtl/core/tgpr_queue.sv
// Short job queue between front end and pixel back end.
module tgpr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  tgpr_pkg::push_t  push,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output tgpr_pkg::job_t   head
);

    localparam int PW = $clog2(tgpr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tgpr_pkg::QUEUE_DEPTH + 1);

    tgpr_pkg::job_t  entry_reg [tgpr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(tgpr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CW'(tgpr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push.push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// File: rtl/core/tgpr_back.sv
// Back end: font store, glyph scan and pixel write generation.
module tgpr_back #(
    parameter int GLYPH_COUNT = tgpr_pkg::GLYPH_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tgpr_pkg::cfg_t      cfg,
    input  tgpr_pkg::job_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                clear_busy,
    output logic                m_valid,
    input  logic                m_ready,
    output tgpr_pkg::out_item_t m_item
);

    localparam int DEPTH = GLYPH_COUNT * tgpr_pkg::GLYPH_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GLYPH_COUNT);

    logic [7:0] font_mem [DEPTH];

    tgpr_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0]      clr_cnt_reg;
    logic [CW-1:0]      code_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic [31:0]        color_reg;
    logic [2:0]         row_reg, col_reg;
    logic               row_ok_reg;
    logic [28:0]        prod_reg;
    logic [7:0]         bits_reg;
    logic               pend_valid_reg;
    logic [31:0]        pend_addr_reg;
    logic               m_valid_reg;
    tgpr_pkg::out_item_t m_item_reg;

    logic               glyph_ok;
    logic signed [16:0] py, px;
    logic               py_ok, px_ok, hit, out_free;
    logic [31:0]        pix_addr;
    logic               mem_we, mem_re, start_job, step, flush;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;

    assign glyph_ok = ({1'b0, head.char_code} < 9'(GLYPH_COUNT));
    assign py       = {cy_reg[15], cy_reg} + {14'b0, row_reg};
    assign px       = {cx_reg[15], cx_reg} + {14'b0, col_reg};
    assign py_ok    = !py[16] && (py[15:0] < {3'b0, cfg.screen_height});
    assign px_ok    = !px[16] && (px[15:0] < {3'b0, cfg.screen_width});
    assign hit      = bits_reg[3'd7 - col_reg] && row_ok_reg && px_ok;
    assign pix_addr = {2'b0, cfg.buffer_base} + {3'b0, prod_reg} + {17'b0, px[12:0], 2'b00};
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = clr_cnt_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        start_job  = 1'b0;
        step       = 1'b0;
        flush      = 1'b0;
        clear_busy = (state_reg == tgpr_pkg::BK_CLEAR);
        case (state_reg)
            tgpr_pkg::BK_CLEAR: begin
                mem_we = 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = tgpr_pkg::BK_IDLE;
                end
            end
            tgpr_pkg::BK_IDLE: begin
                if (!empty) begin
                    pop = 1'b1;
                    if (!head.is_draw) begin
                        mem_we    = glyph_ok;
                        mem_waddr = {head.char_code[CW-1:0], head.glyph_row};
                        mem_wdata = head.row_bits;
                    end else if (glyph_ok && cfg.buffer_base != '0) begin
                        start_job  = 1'b1;
                        state_next = tgpr_pkg::BK_FETCH;
                    end
                end
            end
            tgpr_pkg::BK_FETCH: begin
                mem_re     = 1'b1;
                state_next = tgpr_pkg::BK_SCAN;
            end
            tgpr_pkg::BK_SCAN: begin
                if (!(hit && pend_valid_reg && !out_free)) begin
                    step = 1'b1;
                    if (col_reg == 3'd7) begin
                        state_next = (row_reg == 3'd7) ? tgpr_pkg::BK_FLUSH
                                                       : tgpr_pkg::BK_FETCH;
                    end
                end
            end
            tgpr_pkg::BK_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    flush      = 1'b1;
                    state_next = tgpr_pkg::BK_IDLE;
                end
            end
            default: state_next = tgpr_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tgpr_pkg::BK_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tgpr_pkg::BK_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (m_valid_reg && m_ready && !(pend_valid_reg && ((step && hit) || flush))) begin
                m_valid_reg <= 1'b0;
            end
            if (step && hit) begin
                if (pend_valid_reg) begin
                    m_valid_reg <= 1'b1;
                    m_item_reg  <= {pend_addr_reg, color_reg, 1'b0};
                end
                pend_valid_reg <= 1'b1;
                pend_addr_reg  <= pix_addr;
            end
            if (flush && pend_valid_reg) begin
                m_valid_reg    <= 1'b1;
                m_item_reg     <= {pend_addr_reg, color_reg, 1'b1};
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_job) begin
            code_reg  <= head.char_code[CW-1:0];
            cx_reg    <= head.col_pos;
            cy_reg    <= head.row_pos;
            color_reg <= head.color;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        if (mem_re) begin
            row_ok_reg <= py_ok;
            prod_reg   <= {16'b0, py[12:0]} * {13'b0, cfg.row_pitch};
        end
        if (step) begin
            col_reg <= col_reg + 1'b1;
            if (col_reg == 3'd7) begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            font_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            bits_reg <= font_mem[{code_reg, row_reg}];
        end
    end

endmodule

// File: rtl/core/text_glyph_pixel_renderer.sv
// Top level: register port, front end, job queue and pixel back end.
// Load, start and newline items are taken whenever s_ready is high; loads queue for the back end.
// A drawn character holds the back end for 8 rows of 1 font read and 8 column scans, then a flush, set
// by the single font store read port and one column per cycle unless a hit waits on m_ready; writes leave at most one a cycle.
// Each write is held until the next one or the end of the character; an item passes the queue, IDLE, FETCH, SCAN first.
// Reset is synchronous; afterwards all GLYPH_COUNT*8 font store entries are cleared in turn,
// during which s_ready stays low; register writes are taken throughout.
module text_glyph_pixel_renderer #(
    parameter int GLYPH_COUNT = tgpr_pkg::GLYPH_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tgpr_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tgpr_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tgpr_pkg::out_item_t         m_item
);

    tgpr_pkg::cfg_t  cfg_reg;
    tgpr_pkg::push_t push;
    tgpr_pkg::job_t  head;
    logic            queue_full, queue_empty, pop, clear_busy;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            tgpr_pkg::REG_WIDTH:  prdata = {19'b0, cfg_reg.screen_width};
            tgpr_pkg::REG_HEIGHT: prdata = {19'b0, cfg_reg.screen_height};
            tgpr_pkg::REG_PITCH:  prdata = {16'b0, cfg_reg.row_pitch};
            tgpr_pkg::REG_BASE:   prdata = {2'b0, cfg_reg.buffer_base};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= tgpr_pkg::WIDTH_RST;
            cfg_reg.screen_height <= tgpr_pkg::HEIGHT_RST;
            cfg_reg.row_pitch     <= tgpr_pkg::PITCH_RST;
            cfg_reg.buffer_base   <= tgpr_pkg::BASE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tgpr_pkg::REG_WIDTH:  cfg_reg.screen_width  <= pwdata[12:0];
                tgpr_pkg::REG_HEIGHT: cfg_reg.screen_height <= pwdata[12:0];
                tgpr_pkg::REG_PITCH:  cfg_reg.row_pitch     <= pwdata[15:0];
                tgpr_pkg::REG_BASE:   cfg_reg.buffer_base   <= pwdata[29:0];
                default: ;
            endcase
        end
    end

    tgpr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .clear_busy (clear_busy),
        .queue_full (queue_full),
        .push       (push)
    );

    tgpr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (queue_full),
        .empty   (queue_empty),
        .head    (head)
    );

    tgpr_back #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head       (head),
        .empty      (queue_empty),
        .pop        (pop),
        .clear_busy (clear_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

// File: rtl/core/tgpr_checker.sv
// Port-level assertions for the glyph pixel renderer, bound to the top level.
module tgpr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tgpr_pkg::out_item_t m_item
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("output item changed while stalled");

    a_reset_no_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready before font clear started");

    a_clear_runs: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !s_ready)
        else $error("font clear ended too early");

endmodule

bind text_glyph_pixel_renderer tgpr_checker u_tgpr_checker (.*);
